>>> rtl/svq_pkg.sv
package svq_pkg;

    localparam int EDGE_SLOTS = 4096;
    localparam int MAX_FACES  = 65536;

    localparam int SLOT_W   = $clog2(EDGE_SLOTS);
    localparam int FILL_W   = $clog2(EDGE_SLOTS + 1);
    localparam int FACE_W   = $clog2(MAX_FACES + 1);
    localparam int VERT_W   = 16;
    localparam int IDX_W    = 18;
    localparam int ATTR_W   = 32;
    localparam int MAX_RES  = 7;
    localparam int RES_W    = $clog2(MAX_RES + 1);
    localparam int BUF_W    = $clog2(MAX_RES);

    // edge order within one triangle
    localparam logic [1:0] EDGE_AB = 2'd0;
    localparam logic [1:0] EDGE_BC = 2'd1;
    localparam logic [1:0] EDGE_CA = 2'd2;

    typedef struct packed {
        logic                valid;
        logic [2*VERT_W-1:0] key;
        logic [IDX_W-1:0]    end_first;
        logic [IDX_W-1:0]    end_second;
    } edge_entry_t;

    localparam int ENTRY_W = $bits(edge_entry_t);

    typedef struct packed {
        logic [IDX_W-1:0] first;
        logic [IDX_W-1:0] second;
        logic [IDX_W-1:0] third;
    } tri_t;

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_SCAN_RD = 7'b0000010,
        ST_SCAN_CK = 7'b0000100,
        ST_DECIDE  = 7'b0001000,
        ST_HIT_A   = 7'b0010000,
        ST_HIT_B   = 7'b0100000,
        ST_OUT     = 7'b1000000
    } state_t;

endpackage

>>> rtl/svq_ram.sv
module svq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> rtl/shadow_volume_edge_quad_builder_core.sv
// Shadow volume edge quad builder.
// Input channel (in_valid / in_stall) takes one triangle per item: three
// original vertex indices, a material attribute and a last_face mark.
// Output channel (out_valid / out_stall) returns 1 to 7 triangle items:
// first the face re-indexed onto three fresh vertices, then two degenerate
// quad triangles for every edge that meets its reversed partner in the table.
// The edge table lives in one RAM scanned linearly up to its fill mark,
// with a read step and a check step per slot, one scan per edge. An edge
// that misses scans to the fill mark and then decides; a hit stops at its
// slot, erases it and builds the pair. Results then follow at one per cycle
// while out_stall is low. One item is in work at a time; in_stall is high
// from accept until the last result is taken, and the next item can be
// accepted in the cycle after that.
// Results are held in a small buffer until the item is finished, so the
// overflow flag is correct on every result. A stalled output holds its
// item unchanged. Reset clears the face counter and the fill mark, which
// empties the table at once (no clearing pass); an item with last_face
// clears the face counter on accept and the fill mark after its last
// result is taken.
module shadow_volume_edge_quad_builder_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] vert_a,
    input  logic [15:0] vert_b,
    input  logic [15:0] vert_c,
    input  logic [31:0] face_attribute,
    input  logic        last_face,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [17:0] tri_first,
    output logic [17:0] tri_second,
    output logic [17:0] tri_third,
    output logic [31:0] out_attribute,
    output logic        is_quad,
    output logic        overflow,
    output logic        last_result
);

    import svq_pkg::*;

    state_t state_reg, state_next;

    logic [FACE_W-1:0] face_reg, face_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] idx_reg, idx_next;
    logic [1:0]        edge_reg, edge_next;
    logic [RES_W-1:0]  cnt_reg, cnt_next;
    logic [RES_W-1:0]  oidx_reg, oidx_next;
    logic              ovf_reg, ovf_next;
    logic              last_reg, last_next;
    logic              fwd_reg, fwd_next;
    logic              free_reg, free_next;
    logic [SLOT_W-1:0] free_slot_reg, free_slot_next;
    logic [SLOT_W-1:0] hit_slot_reg, hit_slot_next;

    // payload registers
    logic [VERT_W-1:0] a_reg, b_reg, c_reg;
    logic [ATTR_W-1:0] attr_reg;
    logic [IDX_W-1:0]  na_reg, nb_reg, nc_reg;
    logic [IDX_W-1:0]  e1_reg, e2_reg;
    tri_t              res_buf [MAX_RES];

    // ram ports
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    edge_entry_t       wr_entry;
    logic [SLOT_W-1:0] rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    edge_entry_t       rd_entry;

    // current edge operands
    logic [VERT_W-1:0] o1, o2;
    logic [IDX_W-1:0]  n1, n2;
    logic [2*VERT_W-1:0] key_rev, key_fwd;

    // new face indices at accept
    logic [FACE_W-1:0] face_use;
    logic [IDX_W-1:0]  face_lo, na_in;
    logic              accept_in, accept_out, res_last;

    svq_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(EDGE_SLOTS)
    ) u_table (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_entry),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign rd_entry = edge_entry_t'(rd_data);
    assign rd_addr  = idx_reg[SLOT_W-1:0];

    // edge operand select
    always_comb
    begin
        case (edge_reg)
            EDGE_AB:
            begin
                o1 = a_reg; o2 = b_reg; n1 = na_reg; n2 = nb_reg;
            end
            EDGE_BC:
            begin
                o1 = b_reg; o2 = c_reg; n1 = nb_reg; n2 = nc_reg;
            end
            default:
            begin
                o1 = c_reg; o2 = a_reg; n1 = nc_reg; n2 = na_reg;
            end
        endcase
    end

    assign key_rev = {o2, o1};
    assign key_fwd = {o1, o2};

    // face index with saturation
    assign face_use = (face_reg >= FACE_W'(MAX_FACES)) ? FACE_W'(MAX_FACES) : face_reg;
    assign face_lo  = IDX_W'(face_use);
    assign na_in    = face_lo + {face_lo[IDX_W-2:0], 1'b0};

    assign accept_in  = in_valid && !in_stall;
    assign accept_out = out_valid && !out_stall;
    assign res_last   = (oidx_reg == cnt_reg - RES_W'(1));

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        face_next      = face_reg;
        fill_next      = fill_reg;
        idx_next       = idx_reg;
        edge_next      = edge_reg;
        cnt_next       = cnt_reg;
        oidx_next      = oidx_reg;
        ovf_next       = ovf_reg;
        last_next      = last_reg;
        fwd_next       = fwd_reg;
        free_next      = free_reg;
        free_slot_next = free_slot_reg;
        hit_slot_next  = hit_slot_reg;
        wr_en          = 1'b0;
        wr_addr        = hit_slot_reg;
        wr_entry       = '{valid: 1'b0, key: key_fwd, end_first: n1, end_second: n2};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_in)
                begin
                    ovf_next  = (face_reg >= FACE_W'(MAX_FACES));
                    last_next = last_face;
                    if (last_face)
                    begin
                        face_next = '0;
                    end
                    else if (face_reg < FACE_W'(MAX_FACES))
                    begin
                        face_next = face_reg + FACE_W'(1);
                    end
                    cnt_next   = RES_W'(1);
                    edge_next  = EDGE_AB;
                    idx_next   = '0;
                    fwd_next   = 1'b0;
                    free_next  = 1'b0;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:
            begin
                if (idx_reg == fill_reg)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    state_next = ST_SCAN_CK;
                end
            end
            ST_SCAN_CK:
            begin
                if (rd_entry.valid && rd_entry.key == key_rev)
                begin
                    hit_slot_next = idx_reg[SLOT_W-1:0];
                    state_next    = ST_HIT_A;
                end
                else
                begin
                    if (rd_entry.valid && rd_entry.key == key_fwd)
                    begin
                        fwd_next = 1'b1;
                    end
                    if (!rd_entry.valid && !free_reg)
                    begin
                        free_next      = 1'b1;
                        free_slot_next = idx_reg[SLOT_W-1:0];
                    end
                    idx_next   = idx_reg + FILL_W'(1);
                    state_next = ST_SCAN_RD;
                end
            end
            ST_DECIDE:
            begin
                wr_entry.valid = 1'b1;
                if (!fwd_reg)
                begin
                    if (free_reg)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = free_slot_reg;
                    end
                    else if (fill_reg < FILL_W'(EDGE_SLOTS))
                    begin
                        wr_en     = 1'b1;
                        wr_addr   = fill_reg[SLOT_W-1:0];
                        fill_next = fill_reg + FILL_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                // next edge or finish
                if (edge_reg == EDGE_CA)
                begin
                    oidx_next  = '0;
                    state_next = ST_OUT;
                end
                else
                begin
                    edge_next  = edge_reg + 2'd1;
                    idx_next   = '0;
                    fwd_next   = 1'b0;
                    free_next  = 1'b0;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_HIT_A:
            begin
                // erase the matched entry
                wr_en      = 1'b1;
                wr_addr    = hit_slot_reg;
                cnt_next   = cnt_reg + RES_W'(1);
                state_next = ST_HIT_B;
            end
            ST_HIT_B:
            begin
                cnt_next = cnt_reg + RES_W'(1);
                if (edge_reg == EDGE_CA)
                begin
                    oidx_next  = '0;
                    state_next = ST_OUT;
                end
                else
                begin
                    edge_next  = edge_reg + 2'd1;
                    idx_next   = '0;
                    fwd_next   = 1'b0;
                    free_next  = 1'b0;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_OUT:
            begin
                if (accept_out)
                begin
                    if (res_last)
                    begin
                        if (last_reg)
                        begin
                            fill_next = '0;
                        end
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        oidx_next = oidx_reg + RES_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            face_reg      <= '0;
            fill_reg      <= '0;
            idx_reg       <= '0;
            edge_reg      <= EDGE_AB;
            cnt_reg       <= '0;
            oidx_reg      <= '0;
            ovf_reg       <= 1'b0;
            last_reg      <= 1'b0;
            fwd_reg       <= 1'b0;
            free_reg      <= 1'b0;
            free_slot_reg <= '0;
            hit_slot_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            face_reg      <= face_next;
            fill_reg      <= fill_next;
            idx_reg       <= idx_next;
            edge_reg      <= edge_next;
            cnt_reg       <= cnt_next;
            oidx_reg      <= oidx_next;
            ovf_reg       <= ovf_next;
            last_reg      <= last_next;
            fwd_reg       <= fwd_next;
            free_reg      <= free_next;
            free_slot_reg <= free_slot_next;
            hit_slot_reg  <= hit_slot_next;
        end
    end

    // item payload and result buffer
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            a_reg      <= vert_a;
            b_reg      <= vert_b;
            c_reg      <= vert_c;
            attr_reg   <= face_attribute;
            na_reg     <= na_in;
            nb_reg     <= na_in + IDX_W'(1);
            nc_reg     <= na_in + IDX_W'(2);
            res_buf[0] <= '{first: na_in, second: na_in + IDX_W'(1),
                            third: na_in + IDX_W'(2)};
        end
        if (state_reg == ST_SCAN_CK)
        begin
            e1_reg <= rd_entry.end_first;
            e2_reg <= rd_entry.end_second;
        end
        if (state_reg == ST_HIT_A)
        begin
            res_buf[cnt_reg[BUF_W-1:0]] <= '{first: n1, second: e2_reg, third: e1_reg};
        end
        if (state_reg == ST_HIT_B)
        begin
            res_buf[cnt_reg[BUF_W-1:0]] <= '{first: n1, second: e1_reg, third: n2};
        end
    end

    // handshake and result fields
    assign in_stall      = (state_reg != ST_IDLE);
    assign out_valid     = (state_reg == ST_OUT);
    assign tri_first     = res_buf[oidx_reg[BUF_W-1:0]].first;
    assign tri_second    = res_buf[oidx_reg[BUF_W-1:0]].second;
    assign tri_third     = res_buf[oidx_reg[BUF_W-1:0]].third;
    assign is_quad       = (oidx_reg != '0);
    assign out_attribute = is_quad ? '0 : attr_reg;
    assign overflow      = ovf_reg;
    assign last_result   = res_last;

endmodule

>>> tb/testbench.sv
module testbench;
    import svq_pkg::*;

    localparam int WATCHDOG_LIMIT = 150000;

    typedef struct packed {
        logic [IDX_W-1:0]  first;
        logic [IDX_W-1:0]  second;
        logic [IDX_W-1:0]  third;
        logic [ATTR_W-1:0] attribute;
        logic              quad;
        logic              ovf;
        logic              last;
    } out_tri_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [15:0]       vert_a;
    logic [15:0]       vert_b;
    logic [15:0]       vert_c;
    logic [31:0]       face_attribute;
    logic              last_face;
    logic              out_valid;
    logic              out_stall;
    logic [17:0]       tri_first;
    logic [17:0]       tri_second;
    logic [17:0]       tri_third;
    logic [31:0]       out_attribute;
    logic              is_quad;
    logic              overflow;
    logic              last_result;

    // predictor state
    int                faces_seen;
    logic [31:0]       slot_key   [EDGE_SLOTS];
    logic [IDX_W-1:0]  slot_end1  [EDGE_SLOTS];
    logic [IDX_W-1:0]  slot_end2  [EDGE_SLOTS];
    logic              slot_used  [EDGE_SLOTS];

    out_tri_t          pending_tris[$];
    out_tri_t          item_tris[$];
    int                errors;
    int                idle_cycles;
    int                stall_left;

    shadow_volume_edge_quad_builder_core u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .vert_a         (vert_a),
        .vert_b         (vert_b),
        .vert_c         (vert_c),
        .face_attribute (face_attribute),
        .last_face      (last_face),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .tri_first      (tri_first),
        .tri_second     (tri_second),
        .tri_third      (tri_third),
        .out_attribute  (out_attribute),
        .is_quad        (is_quad),
        .overflow       (overflow),
        .last_result    (last_result)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int find_slot(logic [31:0] key);
        for (int i = 0; i < EDGE_SLOTS; i++)
            if (slot_used[i] && slot_key[i] == key)
                return i;
        return -1;
    endfunction

    function automatic out_tri_t make_tri(logic [IDX_W-1:0] p, logic [IDX_W-1:0] q,
                                          logic [IDX_W-1:0] r, logic [31:0] attr,
                                          logic quad);
        out_tri_t t;
        t.first     = p;
        t.second    = q;
        t.third     = r;
        t.attribute = attr;
        t.quad      = quad;
        t.ovf       = 1'b0;
        t.last      = 1'b0;
        return t;
    endfunction

    // one edge: pair with reversed partner or store it
    task automatic match_edge(logic [15:0] o1, logic [15:0] o2,
                              logic [IDX_W-1:0] n1, logic [IDX_W-1:0] n2,
                              inout logic ovf);
        int s;
        int f;
        s = find_slot({o2, o1});
        if (s >= 0)
        begin
            item_tris.insert(item_tris.size(),
                             make_tri(n1, slot_end2[s], slot_end1[s], 32'd0, 1'b1));
            item_tris.insert(item_tris.size(),
                             make_tri(n1, slot_end1[s], n2, 32'd0, 1'b1));
            slot_used[s] = 1'b0;
        end
        else if (find_slot({o1, o2}) < 0)
        begin
            f = -1;
            for (int i = 0; i < EDGE_SLOTS && f < 0; i++)
                if (!slot_used[i])
                    f = i;
            if (f < 0)
                ovf = 1'b1;
            else
            begin
                slot_key[f]  = {o1, o2};
                slot_end1[f] = n1;
                slot_end2[f] = n2;
                slot_used[f] = 1'b1;
            end
        end
    endtask

    // expected triangles of one accepted item
    task automatic predict_triangles(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                                     logic [31:0] attr, logic last);
        logic             ovf;
        logic [IDX_W-1:0] na;
        logic [IDX_W-1:0] nb;
        logic [IDX_W-1:0] nc;
        ovf = 1'b0;
        if (faces_seen >= MAX_FACES)
        begin
            faces_seen = MAX_FACES;
            ovf = 1'b1;
        end
        na = IDX_W'(3 * faces_seen);
        nb = na + 1'b1;
        nc = na + 2'd2;
        item_tris.delete();
        item_tris.insert(item_tris.size(), make_tri(na, nb, nc, attr, 1'b0));
        match_edge(a, b, na, nb, ovf);
        match_edge(b, c, nb, nc, ovf);
        match_edge(c, a, nc, na, ovf);
        for (int i = 0; i < item_tris.size(); i++)
        begin
            item_tris[i].ovf  = ovf;
            item_tris[i].last = (i == item_tris.size() - 1);
            pending_tris.insert(pending_tris.size(), item_tris[i]);
        end
        if (faces_seen < MAX_FACES)
            faces_seen++;
        if (last)
        begin
            faces_seen = 0;
            for (int i = 0; i < EDGE_SLOTS; i++)
                slot_used[i] = 1'b0;
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // send one item and hold it until taken
    task automatic send_triangle(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                                 logic [31:0] attr, logic last, int gap);
        in_valid       <= 1'b1;
        vert_a         <= a;
        vert_b         <= b;
        vert_c         <= c;
        face_attribute <= attr;
        last_face      <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_triangles(a, b, c, attr, last);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_tris.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    // extremes of every field
    task automatic test_field_extremes();
        send_triangle(16'h0000, 16'h0000, 16'h0000, 32'h0000_0000, 1'b0, pick_gap());
        send_triangle(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, pick_gap());
        send_triangle(16'h0000, 16'hFFFF, 16'h5555, 32'hAAAA_5555, 1'b0, pick_gap());
        send_triangle(16'hFFFF, 16'h0000, 16'hAAAA, 32'h5555_AAAA, 1'b1, pick_gap());
    endtask

    // repeated vertices pair edges within one item
    task automatic test_repeated_vertices();
        send_triangle(16'd5, 16'd5, 16'd5, 32'd1, 1'b0, pick_gap());
        send_triangle(16'd7, 16'd7, 16'd9, 32'd2, 1'b0, pick_gap());
        send_triangle(16'd9, 16'd7, 16'd7, 32'd3, 1'b1, pick_gap());
    endtask

    // closed tetrahedron, edge stored twice the same way, end of mesh
    task automatic test_closed_mesh();
        send_triangle(16'd0, 16'd1, 16'd2, 32'h10, 1'b0, pick_gap());
        send_triangle(16'd0, 16'd1, 16'd2, 32'h11, 1'b0, pick_gap());
        send_triangle(16'd0, 16'd3, 16'd1, 32'h12, 1'b0, pick_gap());
        send_triangle(16'd1, 16'd3, 16'd2, 32'h13, 1'b0, pick_gap());
        send_triangle(16'd0, 16'd2, 16'd3, 32'h14, 1'b1, pick_gap());
        // table is empty again, so the reversed edge finds nothing
        send_triangle(16'd2, 16'd1, 16'd0, 32'h15, 1'b1, pick_gap());
        wait_drained();
    endtask

    // meshes drawn from a small vertex pool so edges pair often
    task automatic test_random_meshes(int count);
        int          sent;
        int          len;
        logic [15:0] base;
        int          spread;
        sent = 0;
        while (sent < count)
        begin
            len    = $urandom_range(1, 30);
            base   = 16'($urandom);
            spread = $urandom_range(2, 6);
            for (int i = 0; i < len; i++)
                send_triangle(base + 16'($urandom_range(0, spread)),
                              base + 16'($urandom_range(0, spread)),
                              base + 16'($urandom_range(0, spread)),
                              ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 7))
                                                          : 32'($urandom),
                              i == len - 1, pick_gap());
            sent += len;
            if ($urandom_range(0, 5) == 0)
                wait_drained();
        end
    endtask

    // unrelated vertices, random mesh ends
    task automatic test_noise(int count);
        for (int i = 0; i < count; i++)
            send_triangle(16'($urandom), 16'($urandom), 16'($urandom), 32'($urandom),
                          $urandom_range(0, 7) == 0, pick_gap());
        send_triangle(16'd1, 16'd2, 16'd3, 32'd0, 1'b1, 0);
    endtask

    task automatic report_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t %s mismatch: expected %h actual %h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // result checking, receiver stalls and watchdog
    always @(posedge clk)
    begin
        out_tri_t exp_t;
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
            if (out_valid && !out_stall)
            begin
                if (pending_tris.size() == 0)
                begin
                    $display("%0t unexpected result: actual %h %h %h", $time,
                             tri_first, tri_second, tri_third);
                    errors++;
                end
                else
                begin
                    exp_t = pending_tris.pop_front();
                    report_field("tri_first", 32'(exp_t.first), 32'(tri_first));
                    report_field("tri_second", 32'(exp_t.second), 32'(tri_second));
                    report_field("tri_third", 32'(exp_t.third), 32'(tri_third));
                    report_field("out_attribute", exp_t.attribute, out_attribute);
                    report_field("is_quad", 32'(exp_t.quad), 32'(is_quad));
                    report_field("overflow", 32'(exp_t.ovf), 32'(overflow));
                    report_field("last_result", 32'(exp_t.last), 32'(last_result));
                end
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_stall  <= 1'b1;
            end
            else
            begin
                case ($urandom_range(0, 19))
                    0:       stall_left <= $urandom_range(10, 40);
                    1, 2, 3: stall_left <= $urandom_range(0, 2);
                    default: stall_left <= 0;
                endcase
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        int wait_cycles;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        vert_a         = '0;
        vert_b         = '0;
        vert_c         = '0;
        face_attribute = '0;
        last_face      = 1'b0;
        out_stall      = 1'b0;
        errors         = 0;
        idle_cycles    = 0;
        stall_left     = 0;
        faces_seen     = 0;
        for (int i = 0; i < EDGE_SLOTS; i++)
            slot_used[i] = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        test_repeated_vertices();
        test_closed_mesh();
        test_random_meshes(220);
        test_noise(60);

        in_valid <= 1'b0;
        wait_cycles = 0;
        while (pending_tris.size() != 0 && wait_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (20) @(posedge clk);
        if (errors == 0 && pending_tris.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
